### rtl/core/vlmd_pkg.sv
// ----------------------------------------------------------------------------
// vlmd_pkg
// Shared types, constants and level geometry for the voxel detail pyramid.
// ----------------------------------------------------------------------------
package vlmd_pkg;

	localparam int CW_LOG2       = 4;
	localparam int CH_LOG2       = 5;
	localparam int CHUNK_WIDTH   = 1 << CW_LOG2;
	localparam int COLUMN_HEIGHT = 1 << CH_LOG2;
	localparam int TYPE_COUNT    = 4;
	localparam int LEVELS        = 4;

	localparam int OP_W     = 2;
	localparam int LVL_W    = 3;
	localparam int IDX_W    = 13;
	localparam int TYPE_W   = 2;
	localparam int ORIGIN_W = 16;
	localparam int POSXZ_W  = 21;
	localparam int POSY_W   = 10;
	localparam int CFG_AW   = 4;

	localparam int TYPE_SLOTS = 1 << TYPE_W;
	localparam int CNT_W      = 4;

	function automatic int unsigned cells_of(int unsigned lvl);
		return 1 << (2 * (CW_LOG2 - lvl) + (CH_LOG2 - lvl));
	endfunction

	function automatic int unsigned base_of(int unsigned lvl);
		int unsigned acc;
		acc = 0;
		for (int unsigned k = 1; k <= LEVELS; k++) begin
			if (k < lvl) acc = acc + cells_of(k);
		end
		return acc;
	endfunction

	localparam int FINE_CELLS   = cells_of(0);
	localparam int COARSE_CELLS = base_of(LEVELS + 1);
	localparam int FINE_AW      = $clog2(FINE_CELLS);
	localparam int COARSE_AW    = $clog2(COARSE_CELLS);
	localparam int LCNT_W       = FINE_AW + 1;
	localparam int TGT_W        = $clog2(cells_of(1));

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z = CFG_AW'(1);

	typedef enum logic [1:0] {
		BLD_IDLE,
		BLD_RUN,
		BLD_DRAIN
	} bld_state_t;

	typedef struct packed {
		logic                 fine_we;
		logic [FINE_AW-1:0]   fine_waddr;
		logic [TYPE_W-1:0]    fine_wdata;
		logic                 fine_re;
		logic [FINE_AW-1:0]   fine_raddr;
		logic                 coarse_we;
		logic [COARSE_AW-1:0] coarse_waddr;
		logic [TYPE_W-1:0]    coarse_wdata;
		logic                 coarse_re;
		logic [COARSE_AW-1:0] coarse_raddr;
	} mem_req_t;

	typedef struct packed {
		logic [TYPE_W-1:0] fine_rdata;
		logic [TYPE_W-1:0] coarse_rdata;
	} mem_rsp_t;

	// Cell count of a level; zero for levels beyond the pyramid.
	function automatic logic [LCNT_W-1:0] lvl_cells(logic [LVL_W-1:0] lvl);
		logic [LCNT_W-1:0] n;
		n = '0;
		for (int unsigned k = 0; k <= LEVELS; k++) begin
			if (lvl == LVL_W'(k)) n = LCNT_W'(cells_of(k));
		end
		return n;
	endfunction

	// Offset of a coarse level inside the coarse store.
	function automatic logic [COARSE_AW-1:0] lvl_base(logic [LVL_W-1:0] lvl);
		logic [COARSE_AW-1:0] b;
		b = '0;
		for (int unsigned k = 1; k <= LEVELS; k++) begin
			if (lvl == LVL_W'(k)) b = COARSE_AW'(base_of(k));
		end
		return b;
	endfunction

endpackage

### rtl/core/vlmd_ifs.sv
// ----------------------------------------------------------------------------
// vlmd_ifs
// Valid/ready channels: request items, result items and register writes.
// ----------------------------------------------------------------------------
interface vlmd_req_if import vlmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [LVL_W-1:0]  lod_level;
	logic [IDX_W-1:0]  cell_index;
	logic [TYPE_W-1:0] cell_type;

	modport source (output valid, op, lod_level, cell_index, cell_type, input ready);
	modport sink   (input valid, op, lod_level, cell_index, cell_type, output ready);
endinterface

interface vlmd_rsp_if import vlmd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [TYPE_W-1:0]         type_out;
	logic signed [POSXZ_W-1:0] pos_x_half;
	logic [POSY_W-1:0]         pos_y_half;
	logic signed [POSXZ_W-1:0] pos_z_half;
	logic                      valid_res;

	modport source (output valid, type_out, pos_x_half, pos_y_half, pos_z_half, valid_res,
		input ready);
	modport sink   (input valid, type_out, pos_x_half, pos_y_half, pos_z_half, valid_res,
		output ready);
endinterface

interface vlmd_cfg_if import vlmd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_AW-1:0]   addr;
	logic [ORIGIN_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/core/voxel_lod_majority_downsample.sv
// ----------------------------------------------------------------------------
// voxel_lod_majority_downsample
// Voxel chunk detail pyramid: level-0 loads, 2x2x2 majority build of four
// coarser levels, and cell reads with world position in half units.
// ----------------------------------------------------------------------------
//
//   channel  side  beat content
//   -------  ----  --------------------------------------------------------
//   req      in    op, lod_level, cell_index, cell_type
//   rsp      out   type_out, pos_x_half, pos_y_half, pos_z_half, valid_res
//   cfg      in    addr (0 origin x, 1 origin z), data; always ready
//
// Loads and reads can be accepted back to back unless rsp stalls or a build
// runs; a result passes the registered memory read and then the output register.
// A build beat's zero result takes the same path; from the cycle after the
// beat the sequencer holds req off while it walks the children through the
// memories' single read ports.
// Reset clears control and origins only; memory contents stay undefined
// until loaded or built. A stalled rsp holds the pending result and the
// read data; req backs up behind it.
//
module voxel_lod_majority_downsample import vlmd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	vlmd_req_if.sink  req,
	vlmd_rsp_if.source rsp,
	vlmd_cfg_if.sink  cfg
);

	logic signed [ORIGIN_W-1:0] origin_x_q, origin_z_q;
	logic                       built_q;

	mem_req_t fe_req, bld_req, mem_req;
	mem_rsp_t mem_rsp;
	logic     bld_busy;

	logic acc, out_adv, bld_start;

	// stage 1: memory read in flight
	logic                      vld_s1, ok_s1, fine_s1;
	logic signed [POSXZ_W-1:0] pos_x_s1, pos_z_s1;
	logic [POSY_W-1:0]         pos_y_s1;

	// output register
	logic                      out_vld_q, ok_q;
	logic [TYPE_W-1:0]         type_q;
	logic signed [POSXZ_W-1:0] pos_x_q, pos_z_q;
	logic [POSY_W-1:0]         pos_y_q;

	// front end decode
	logic                      is_load, is_build, rd_ok, load_ok;
	logic [TYPE_W-1:0]         typ_sat;
	logic [IDX_W-1:0]          wl, cmsk, cx, cz, cy;
	logic [POSY_W-1:0]         tx_h, ty_h, tz_h;
	logic signed [POSXZ_W-1:0] ox_h, oz_h, px, pz;

	function automatic logic [POSY_W-1:0] half_term(logic [IDX_W-1:0] c,
		logic [LVL_W-1:0] lvl);
		logic [POSY_W-1:0] cc;
		cc = POSY_W'(c);
		return (cc << (lvl + LVL_W'(1))) + (POSY_W'(1) << lvl) - POSY_W'(1);
	endfunction

	// ---- configuration: always ready, written only while idle, user-enforced
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.addr)
				CFG_ORIGIN_X: origin_x_q <= cfg.data;
				CFG_ORIGIN_Z: origin_z_q <= cfg.data;
				default: ;	// drop writes to unknown registers
			endcase
		end
	end

	// ---- request handshake ----
	// advance the output register when empty or being taken
	assign out_adv   = !out_vld_q || rsp.ready;
	assign req.ready = !bld_busy && (!vld_s1 || out_adv);
	assign acc       = req.valid && req.ready;

	always_comb begin
		is_load  = (req.op == OP_LOAD);
		is_build = (req.op == OP_BUILD);
		load_ok  = is_load && ({1'b0, req.cell_index} < LCNT_W'(FINE_CELLS));
		rd_ok    = (req.op == OP_READ) && (req.lod_level <= LVL_W'(LEVELS)) &&
			({1'b0, req.cell_index} < lvl_cells(req.lod_level)) &&
			(req.lod_level == '0 || built_q);

		// saturate codes at or above the type count
		typ_sat = ({1'b0, req.cell_type} >= (TYPE_W+1)'(TYPE_COUNT)) ?
			TYPE_W'(TYPE_COUNT - 1) : req.cell_type;

		// split the index into x, z, y at this level's width
		wl   = IDX_W'(CW_LOG2) - IDX_W'(req.lod_level);
		cmsk = (IDX_W'(1) << wl) - IDX_W'(1);
		cx   = req.cell_index & cmsk;
		cz   = (req.cell_index >> wl) & cmsk;
		cy   = req.cell_index >> (wl << 1);
		tx_h = half_term(cx, req.lod_level);
		ty_h = half_term(cy, req.lod_level);
		tz_h = half_term(cz, req.lod_level);

		// origin in chunks, scaled to cells and doubled to half units
		ox_h = POSXZ_W'(origin_x_q) <<< (CW_LOG2 + 1);
		oz_h = POSXZ_W'(origin_z_q) <<< (CW_LOG2 + 1);
		px   = ox_h + signed'({{(POSXZ_W-POSY_W){1'b0}}, tx_h});
		pz   = oz_h + signed'({{(POSXZ_W-POSY_W){1'b0}}, tz_h});
	end

	always_comb begin
		fe_req              = '0;
		fe_req.fine_we      = acc && load_ok;
		fe_req.fine_waddr   = FINE_AW'(req.cell_index);
		fe_req.fine_wdata   = typ_sat;
		fe_req.fine_re      = acc && rd_ok && (req.lod_level == '0);
		fe_req.fine_raddr   = FINE_AW'(req.cell_index);
		fe_req.coarse_re    = acc && rd_ok && (req.lod_level != '0);
		fe_req.coarse_raddr = lvl_base(req.lod_level) + COARSE_AW'(req.cell_index);
	end

	// the sequencer owns the memories while a build runs
	assign mem_req   = bld_busy ? bld_req : fe_req;
	assign bld_start = acc && is_build;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
		end else if (acc) begin
			if (is_build) built_q <= 1'b1;
			else if (load_ok) built_q <= 1'b0;
		end
	end

	// ---- stage 1 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (out_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1    <= rd_ok;
			fine_s1  <= (req.lod_level == '0);
			pos_x_s1 <= px;
			pos_y_s1 <= ty_h;
			pos_z_s1 <= pz;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && vld_s1) begin
			ok_q    <= ok_s1;
			type_q  <= !ok_s1 ? '0 : (fine_s1 ? mem_rsp.fine_rdata : mem_rsp.coarse_rdata);
			pos_x_q <= ok_s1 ? pos_x_s1 : '0;
			pos_y_q <= ok_s1 ? pos_y_s1 : '0;
			pos_z_q <= ok_s1 ? pos_z_s1 : '0;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.type_out   = type_q;
	assign rsp.pos_x_half = pos_x_q;
	assign rsp.pos_y_half = pos_y_q;
	assign rsp.pos_z_half = pos_z_q;
	assign rsp.valid_res  = ok_q;

	vlmd_build u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (bld_start),
		.mem_rsp (mem_rsp),
		.mem_req (bld_req),
		.busy    (bld_busy)
	);

	vlmd_store u_store (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	// hold requests off for the whole build
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		bld_busy |-> !req.ready)
		else $error("request accepted during build");

	// a build only starts from a build beat
	a_build_start: assert property (@(posedge clk) disable iff (!arst_n)
		(bld_busy && !$past(bld_busy)) |-> $past(bld_start))
		else $error("build started without a build beat");

	// outside a build, a stalled stage 1 keeps its entry and the pending read data
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !out_adv && !bld_busy) |=>
		(vld_s1 && $stable(pos_x_s1) && $stable(mem_rsp)))
		else $error("stage 1 lost its entry under stall");

	// no front-end memory access while the sequencer runs
	a_no_fe_mem: assert property (@(posedge clk) disable iff (!arst_n)
		bld_busy |-> !(fe_req.fine_we || fe_req.fine_re || fe_req.coarse_re))
		else $error("front end touched memory during build");

endmodule

### rtl/core/vlmd_store.sv
// ----------------------------------------------------------------------------
// vlmd_store
// Level-0 and coarse type memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module vlmd_store import vlmd_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	logic [TYPE_W-1:0] fine_mem   [FINE_CELLS];
	logic [TYPE_W-1:0] coarse_mem [COARSE_CELLS];
	logic [TYPE_W-1:0] fine_rd_q;
	logic [TYPE_W-1:0] coarse_rd_q;

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.fine_we) fine_mem[req.fine_waddr] <= req.fine_wdata;
		if (req.fine_re) fine_rd_q <= fine_mem[req.fine_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.coarse_we) coarse_mem[req.coarse_waddr] <= req.coarse_wdata;
		if (req.coarse_re) coarse_rd_q <= coarse_mem[req.coarse_raddr];
	end

	assign rsp.fine_rdata   = fine_rd_q;
	assign rsp.coarse_rdata = coarse_rd_q;

endmodule

### rtl/core/vlmd_build.sv
// ----------------------------------------------------------------------------
// vlmd_build
// Pyramid sequencer: reads eight children a cell, counts types, writes the
// majority type one level coarser.
// ----------------------------------------------------------------------------
module vlmd_build import vlmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mem_rsp_t mem_rsp,
	output mem_req_t mem_req,
	output logic     busy
);

	bld_state_t state_q, state_nx;
	logic [LVL_W-1:0] lvl_q;
	logic [TGT_W-1:0] tgt_q;
	logic [2:0]       dsel_q;

	logic issue, lvl_step, restart;

	logic                 vld_s1, last_s1, fine_s1;
	logic [COARSE_AW-1:0] dst_s1;

	logic [TYPE_SLOTS-1:0][CNT_W-1:0] cnt_q, cnt_nx;
	logic [TYPE_W-1:0] child, best;

	logic [FINE_AW-1:0] tg, msk, tx, tz, ty, src;
	logic [FINE_AW-1:0] twl, swl;
	logic               tgt_last;

	// child address of the current target cell, one level finer
	always_comb begin
		twl = FINE_AW'(CW_LOG2) - FINE_AW'(lvl_q);
		swl = twl + FINE_AW'(1);
		tg  = FINE_AW'(tgt_q);
		msk = (FINE_AW'(1) << twl) - FINE_AW'(1);
		tx  = tg & msk;
		tz  = (tg >> twl) & msk;
		ty  = tg >> (twl << 1);
		src = ((((ty << 1) | FINE_AW'(dsel_q[2])) << (swl << 1)) |
			(((tz << 1) | FINE_AW'(dsel_q[1])) << swl) |
			((tx << 1) | FINE_AW'(dsel_q[0])));
		tgt_last = ({{(LCNT_W-TGT_W){1'b0}}, tgt_q} == lvl_cells(lvl_q) - LCNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BLD_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		issue    = 1'b0;
		lvl_step = 1'b0;
		restart  = 1'b0;
		case (state_q)
			BLD_IDLE: begin
				if (start) begin
					restart  = 1'b1;
					state_nx = BLD_RUN;
				end
			end
			BLD_RUN: begin
				issue = 1'b1;
				if (dsel_q == 3'd7 && tgt_last) state_nx = BLD_DRAIN;
			end
			BLD_DRAIN: begin
				// let the last write of the level land before the next level reads it
				if (lvl_q == LVL_W'(LEVELS)) begin
					state_nx = BLD_IDLE;
				end else begin
					lvl_step = 1'b1;
					state_nx = BLD_RUN;
				end
			end
			default: state_nx = BLD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= LVL_W'(1);
			tgt_q  <= '0;
			dsel_q <= '0;
		end else begin
			if (restart) begin
				lvl_q  <= LVL_W'(1);
				tgt_q  <= '0;
				dsel_q <= '0;
			end else if (lvl_step) begin
				lvl_q <= lvl_q + LVL_W'(1);
			end else if (issue) begin
				dsel_q <= dsel_q + 3'd1;
				if (dsel_q == 3'd7) tgt_q <= tgt_last ? '0 : tgt_q + TGT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (dsel_q == 3'd7);
		fine_s1 <= (lvl_q == LVL_W'(1));
		dst_s1  <= lvl_base(lvl_q) + COARSE_AW'(tgt_q);
	end

	always_comb begin
		child  = fine_s1 ? mem_rsp.fine_rdata : mem_rsp.coarse_rdata;
		cnt_nx = cnt_q;
		for (int t = 0; t < TYPE_SLOTS; t++) begin
			if (vld_s1 && child == TYPE_W'(t)) cnt_nx[t] = cnt_q[t] + CNT_W'(1);
		end
		// tie goes to the lowest code
		best = '0;
		for (int t = 1; t < TYPE_SLOTS; t++) begin
			if (cnt_nx[t] > cnt_nx[best]) best = TYPE_W'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (vld_s1) begin
			cnt_q <= last_s1 ? '0 : cnt_nx;
		end
	end

	always_comb begin
		mem_req              = '0;
		mem_req.fine_re      = issue && (lvl_q == LVL_W'(1));
		mem_req.fine_raddr   = src;
		mem_req.coarse_re    = issue && (lvl_q != LVL_W'(1));
		mem_req.coarse_raddr = lvl_base(lvl_q - LVL_W'(1)) + COARSE_AW'(src);
		mem_req.coarse_we    = vld_s1 && last_s1;
		mem_req.coarse_waddr = dst_s1;
		mem_req.coarse_wdata = best;
	end

	assign busy = (state_q != BLD_IDLE);

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voxel detail pyramid. Loads, majority builds and
// cell reads are mirrored in a behavioral pyramid, and every result beat is
// compared field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module testbench;
	import vlmd_pkg::*;

	localparam int IDLE_PCT     = 38;
	// Bound on how long a build holds req off after its beat, with margin added.
	localparam int BUILD_HOLD   = 9364 + 32;
	// No beat at all for this long means the block is stuck.
	localparam int QUIET_LIMIT  = 40000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int READ_TAIL    = 16;
	localparam int STALL_CYCLES = 400;
	localparam logic [CFG_AW-1:0] CFG_FIRST_UNUSED = CFG_ORIGIN_Z + 1'b1;

	typedef struct {
		logic [TYPE_W-1:0]         kind;
		logic signed [POSXZ_W-1:0] px;
		logic [POSY_W-1:0]         py;
		logic signed [POSXZ_W-1:0] pz;
		logic                      defined;
	} cell_reply_t;

	logic clk;
	logic arst_n;

	vlmd_req_if req_ch ();
	vlmd_rsp_if rsp_ch ();
	vlmd_cfg_if cfg_ch ();

	voxel_lod_majority_downsample i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Behavioral copy of the block: level 0 is the loaded grid, levels 1..4
	// are what the last build derived from it.
	logic [TYPE_W-1:0]   pyramid [0:LEVELS][0:FINE_CELLS-1];
	bit                  levels_ready = 1'b0;
	logic [ORIGIN_W-1:0] org_x = '0;
	logic [ORIGIN_W-1:0] org_z = '0;

	cell_reply_t due_replies [$];

	longint cycle_no     = 0;
	longint build_cycle  = -BUILD_HOLD;
	int     quiet_cycles = 0;
	int     fail_count   = 0;
	int     items_sent   = 0;
	int     hold_request = 0;
	bit     steady_flow  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic int level_size(int lvl);
		if (lvl > LEVELS) return 0;
		return (CHUNK_WIDTH >> lvl) * (CHUNK_WIDTH >> lvl) * (COLUMN_HEIGHT >> lvl);
	endfunction

	// Half-unit position: twice the origin, 2^(lvl+1) half units per cell at the level,
	// and the center offset of a cell that spans 2^lvl grid units.
	function automatic int half_pos(int origin_cells, int c, int lvl);
		return 2 * origin_cells + (c << (lvl + 1)) + (1 << lvl) - 1;
	endfunction

	// Derive each coarse level from the one below it: the most common type
	// among the eight children wins, and a tie keeps the lowest code.
	function automatic void rebuild_pyramid();
		int src_w, dst_w, dst_h, best;
		int tally [TYPE_SLOTS];
		logic [TYPE_W-1:0] t;
		for (int lvl = 1; lvl <= LEVELS; lvl++) begin
			src_w = CHUNK_WIDTH >> (lvl - 1);
			dst_w = src_w >> 1;
			dst_h = (COLUMN_HEIGHT >> (lvl - 1)) >> 1;
			for (int y = 0; y < dst_h; y++)
				for (int z = 0; z < dst_w; z++)
					for (int x = 0; x < dst_w; x++) begin
						for (int k = 0; k < TYPE_SLOTS; k++) tally[k] = 0;
						for (int d = 0; d < 8; d++) begin
							t = pyramid[lvl-1][src_w * src_w * (2 * y + ((d >> 2) & 1))
								+ src_w * (2 * z + ((d >> 1) & 1)) + 2 * x + (d & 1)];
							if (t < TYPE_COUNT) tally[t]++;
						end
						best = 0;
						for (int k = 1; k < TYPE_COUNT; k++)
							if (tally[k] > tally[best]) best = k;
						pyramid[lvl][dst_w * dst_w * y + dst_w * z + x] = TYPE_W'(best);
					end
		end
	endfunction

	// Apply one request beat to the model and return the result it causes.
	function automatic cell_reply_t predict_cell_reply(op_t op, logic [LVL_W-1:0] lvl,
			logic [IDX_W-1:0] idx, logic [TYPE_W-1:0] kind);
		cell_reply_t r;
		int w, n, cx, cy, cz, ox, oz;
		r = '{default: '0};
		case (op)
			OP_LOAD: begin
				if (idx < FINE_CELLS) begin
					pyramid[0][idx] = (kind >= TYPE_COUNT) ? TYPE_W'(TYPE_COUNT - 1) : kind;
					levels_ready = 1'b0;
				end
			end
			OP_BUILD: begin
				rebuild_pyramid();
				levels_ready = 1'b1;
			end
			OP_READ: begin
				n = level_size(lvl);
				if (n != 0 && idx < n && (lvl == 0 || levels_ready)) begin
					w  = CHUNK_WIDTH >> lvl;
					cx = idx % w;
					cz = (idx / w) % w;
					cy = idx / (w * w);
					ox = $signed(org_x) * CHUNK_WIDTH;
					oz = $signed(org_z) * CHUNK_WIDTH;
					r.kind    = pyramid[lvl][idx];
					r.px      = POSXZ_W'(half_pos(ox, cx, lvl));
					r.py      = POSY_W'(half_pos(0, cy, lvl));
					r.pz      = POSXZ_W'(half_pos(oz, cz, lvl));
					r.defined = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Monitor: register writes and request beats feed the model, result beats
	// are checked against the oldest prediction. Sample at the edge, before
	// any nonblocking update of this step lands.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		cell_reply_t want;
		cell_reply_t next_reply;
		bit          moved;
		cycle_no = cycle_no + 1;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				moved = 1'b1;
				if (cfg_ch.addr == CFG_ORIGIN_X) org_x = cfg_ch.data;
				else if (cfg_ch.addr == CFG_ORIGIN_Z) org_z = cfg_ch.data;
			end
			if (req_ch.valid && req_ch.ready) begin
				moved = 1'b1;
				next_reply = predict_cell_reply(op_t'(req_ch.op), req_ch.lod_level,
					req_ch.cell_index, req_ch.cell_type);
				due_replies.insert(due_replies.size(), next_reply);
				if (op_t'(req_ch.op) == OP_BUILD) build_cycle = cycle_no;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				moved = 1'b1;
				if (due_replies.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					want = due_replies.pop_front();
					if (rsp_ch.type_out !== want.kind) begin
						$error("type_out: expected %0d, got %0d", want.kind, rsp_ch.type_out);
						fail_count++;
					end
					if (rsp_ch.pos_x_half !== want.px) begin
						$error("pos_x_half: expected %0d, got %0d", want.px, rsp_ch.pos_x_half);
						fail_count++;
					end
					if (rsp_ch.pos_y_half !== want.py) begin
						$error("pos_y_half: expected %0d, got %0d", want.py, rsp_ch.pos_y_half);
						fail_count++;
					end
					if (rsp_ch.pos_z_half !== want.pz) begin
						$error("pos_z_half: expected %0d, got %0d", want.pz, rsp_ch.pos_z_half);
						fail_count++;
					end
					if (rsp_ch.valid_res !== want.defined) begin
						$error("valid_res: expected %0d, got %0d", want.defined,
							rsp_ch.valid_res);
						fail_count++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	// Watchdog: a build is the longest legal silence; far beyond it, give up.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// Result side: random idling, a calm mode with none, and a long hold-off
	// on request, counted down here.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (steady_flow) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// Offer one request beat and hold it until accepted. Valid stays high on
	// return so a following beat can go out with no bubble.
	task automatic issue_request(input op_t op, input logic [LVL_W-1:0] lvl,
			input logic [IDX_W-1:0] idx, input logic [TYPE_W-1:0] kind);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.lod_level  <= lvl;
		req_ch.cell_index <= idx;
		req_ch.cell_type  <= kind;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every result is back and any build has
	// finished walking the pyramid.
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_replies.size() != 0 || cycle_no - build_cycle < BUILD_HOLD)
			@(posedge clk);
		repeat (READ_TAIL) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_AW-1:0] addr,
			input logic [ORIGIN_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// Set both origins on an idle block; slip in a write to an unmapped index,
	// which must change nothing.
	task automatic write_origins(input logic [ORIGIN_W-1:0] x, input logic [ORIGIN_W-1:0] z);
		settle_block();
		write_register(CFG_ORIGIN_X, x);
		write_register(CFG_AW'($urandom_range((1 << CFG_AW) - 1, CFG_FIRST_UNUSED)),
			ORIGIN_W'($urandom));
		write_register(CFG_ORIGIN_Z, z);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [ORIGIN_W-1:0] pick_origin();
		case ($urandom_range(3))
			0:       return {1'b1, {(ORIGIN_W - 1){1'b0}}};
			1:       return {1'b0, {(ORIGIN_W - 1){1'b1}}};
			default: return ORIGIN_W'($urandom);
		endcase
	endfunction

	// Load every level-0 cell. The lower half of the column gets uniform
	// types, so ties are frequent; the upper half follows coarse blocks with
	// some noise, so upper levels see clear majorities.
	task automatic fill_chunk();
		int cx, cy, cz;
		logic [TYPE_W-1:0] kind;
		for (int i = 0; i < FINE_CELLS; i++) begin
			cx   = i % CHUNK_WIDTH;
			cz   = (i / CHUNK_WIDTH) % CHUNK_WIDTH;
			cy   = i / (CHUNK_WIDTH * CHUNK_WIDTH);
			kind = TYPE_W'((cx >> 2) ^ (cz >> 3) ^ (cy >> 2));
			if (cy < COLUMN_HEIGHT / 2 || $urandom_range(3) == 0) kind = TYPE_W'($urandom);
			issue_request(OP_LOAD, LVL_W'($urandom), IDX_W'(i), kind);
		end
	endtask

	// Read a cell, mostly in range at a real level; only once the grid is full.
	task automatic random_read();
		logic [LVL_W-1:0] lvl;
		logic [IDX_W-1:0] idx;
		int n;
		if ($urandom_range(9) == 0) lvl = LVL_W'($urandom_range(7, LEVELS + 1));
		else lvl = LVL_W'($urandom_range(LEVELS));
		n = level_size(lvl);
		if (n == 0 || $urandom_range(9) == 0) idx = IDX_W'($urandom);
		else idx = IDX_W'($urandom_range(n - 1));
		issue_request(OP_READ, lvl, idx, TYPE_W'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Before any build: loads, level-0 reads of loaded cells, reads of unbuilt or
	// absent levels that must come back all zero; most of those use loaded indices.
	task automatic test_unbuilt_reads();
		issue_request(OP_LOAD, LVL_W'(0), IDX_W'(0), TYPE_W'(2));
		issue_request(OP_LOAD, LVL_W'(7), IDX_W'(FINE_CELLS - 1), TYPE_W'(3));
		issue_request(OP_LOAD, LVL_W'(5), 13'h1555, TYPE_W'(1));
		issue_request(OP_LOAD, LVL_W'(2), 13'h0AAA, TYPE_W'(0));
		issue_request(OP_READ, LVL_W'(0), IDX_W'(0), TYPE_W'(3));
		issue_request(OP_READ, LVL_W'(0), IDX_W'(FINE_CELLS - 1), TYPE_W'(0));
		issue_request(OP_READ, LVL_W'(0), 13'h1555, TYPE_W'(2));
		issue_request(OP_READ, LVL_W'(0), 13'h0AAA, TYPE_W'(1));
		// coarse levels are undefined until a build
		issue_request(OP_READ, LVL_W'(1), IDX_W'(0), TYPE_W'(0));
		issue_request(OP_READ, LVL_W'(LEVELS), IDX_W'(1), TYPE_W'(0));
		// levels beyond the pyramid
		issue_request(OP_READ, LVL_W'(LEVELS + 1), IDX_W'(0), TYPE_W'(0));
		issue_request(OP_READ, LVL_W'(7), 13'h1555, TYPE_W'(3));
		// unused op does nothing
		issue_request(OP_NONE, LVL_W'(7), 13'h1555, TYPE_W'(3));
		issue_request(OP_READ, LVL_W'(0), 13'h1555, TYPE_W'(0));
		// overwrite a cell and read it back
		issue_request(OP_LOAD, LVL_W'(0), IDX_W'(0), TYPE_W'(3));
		issue_request(OP_READ, LVL_W'(0), IDX_W'(0), TYPE_W'(0));
	endtask

	// Fill the whole grid with no idling on either side, build, then read the
	// first and last cell of each level and the first index past each coarse level.
	task automatic test_first_build();
		steady_flow = 1'b1;
		fill_chunk();
		issue_request(OP_BUILD, LVL_W'($urandom), IDX_W'($urandom), TYPE_W'($urandom));
		for (int lvl = 0; lvl <= LEVELS; lvl++) begin
			issue_request(OP_READ, LVL_W'(lvl), IDX_W'(0), TYPE_W'($urandom));
			issue_request(OP_READ, LVL_W'(lvl), IDX_W'(level_size(lvl) - 1), TYPE_W'($urandom));
			if (lvl != 0)
				issue_request(OP_READ, LVL_W'(lvl), IDX_W'(level_size(lvl)), TYPE_W'($urandom));
		end
		steady_flow = 1'b0;
	endtask

	// Corner cells of every level under extreme and random chunk origins.
	task automatic test_origin_extremes();
		logic [ORIGIN_W-1:0] xs [4];
		logic [ORIGIN_W-1:0] zs [4];
		xs = '{16'h7FFF, 16'h8000, 16'hFFFF, pick_origin()};
		zs = '{16'h8000, 16'h7FFF, 16'h0001, pick_origin()};
		for (int s = 0; s < 4; s++) begin
			write_origins(xs[s], zs[s]);
			for (int lvl = 0; lvl <= LEVELS; lvl++) begin
				issue_request(OP_READ, LVL_W'(lvl), IDX_W'(0), TYPE_W'($urandom));
				issue_request(OP_READ, LVL_W'(lvl), IDX_W'(level_size(lvl) - 1),
					TYPE_W'($urandom));
			end
		end
	endtask

	// Hold results off long enough for the block to back up into req while
	// reads keep coming, then pause until everything has drained.
	task automatic test_output_stall();
		hold_request = STALL_CYCLES;
		repeat (60) random_read();
		settle_block();
	endtask

	// Mostly edit sequences, half of them rebuilt, followed by reads, plus reads on a
	// stale pyramid, raw noise, and idle points that change the origins.
	task automatic test_random_traffic();
		int   stop_at;
		int   pick;
		op_t  op;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				repeat ($urandom_range(8, 1))
					issue_request(OP_LOAD, LVL_W'($urandom), IDX_W'($urandom), TYPE_W'($urandom));
				if ($urandom_range(1) == 0)
					issue_request(OP_BUILD, LVL_W'($urandom), IDX_W'($urandom),
						TYPE_W'($urandom));
				repeat ($urandom_range(20, 4)) random_read();
			end else if (pick < 70) begin
				repeat ($urandom_range(16, 4)) random_read();
			end else if (pick < 85) begin
				repeat ($urandom_range(12, 4)) begin
					op = op_t'($urandom_range(3));
					// keep builds rare in noise; each one holds the block for a whole pyramid walk
					if (op == OP_BUILD && $urandom_range(3) != 0) op = OP_NONE;
					issue_request(op, LVL_W'($urandom), IDX_W'($urandom), TYPE_W'($urandom));
				end
			end else if (pick < 94) begin
				repeat ($urandom_range(4, 1))
					issue_request(OP_LOAD, LVL_W'($urandom), IDX_W'($urandom), TYPE_W'($urandom));
				repeat ($urandom_range(10, 4)) random_read();
			end else begin
				write_origins(pick_origin(), pick_origin());
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.op         <= OP_NONE;
		req_ch.lod_level  <= '0;
		req_ch.cell_index <= '0;
		req_ch.cell_type  <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.addr       <= CFG_ORIGIN_X;
		cfg_ch.data       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unbuilt_reads();
		test_first_build();
		test_origin_extremes();
		test_output_stall();
		test_random_traffic();

		settle_block();
		if (due_replies.size() != 0) begin
			$error("%0d results never arrived", due_replies.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/vlmd_pkg.sv
rtl/core/vlmd_ifs.sv
rtl/core/vlmd_store.sv
rtl/core/vlmd_build.sv
rtl/core/voxel_lod_majority_downsample.sv
verif/testbench.sv
